FILE: sv/text_console_writer_assert.svh
// assertion macros shared by the console writer
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int TEXT_ROWS  = 24;
  localparam int TAB_STOP   = 4;

  localparam int TEXT_CELLS = COLUMNS * TEXT_ROWS;
  localparam int ALL_CELLS  = COLUMNS * (TEXT_ROWS + 1);
  localparam int MOVE_CELLS = COLUMNS * (TEXT_ROWS - 1);

  localparam int ADDR_W = $clog2(ALL_CELLS);
  localparam int CELL_W = 16;
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int NIB_W  = 4;
  localparam int IDX_W  = 12;
  localparam int POS_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  // tab stop is a power of two, so the column test is a mask
  localparam logic [COL_W-1:0] TAB_MASK = COL_W'(TAB_STOP - 1);

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // space, fore 7, back 0 / space, fore 0, back 15
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [CELL_W-1:0] WHITE_CELL = 16'hF020;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_BAR   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] rchar;
    logic [NIB_W-1:0]  rfore;
    logic [NIB_W-1:0]  rback;
  } res_t;

endpackage

FILE: sv/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tcw_ctrl.sv
`timescale 1ns / 1ps

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [NIB_W-1:0]  in_color,
  input  logic [IDX_W-1:0]  in_cell_index,
  output mem_req_t          mem_req,
  input  logic [CELL_W-1:0] mem_rdata,
  output logic              res_valid,
  input  logic              res_take,
  output res_t              res
);

  typedef enum logic [8:0] {
    ST_INIT   = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_TAB    = 9'b000000100,
    ST_BAR    = 9'b000001000,
    ST_READ   = 9'b000010000,
    ST_CLEAR  = 9'b000100000,
    ST_SCROLL = 9'b001000000,
    ST_BLANK  = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [NIB_W-1:0]  fore_r, fore_nxt;
  logic [ADDR_W-1:0] baddr_r, baddr_nxt;
  logic              hit_r, hit_nxt;
  logic [CELL_W-1:0] rcell_r, rcell_nxt;

  logic [ADDR_W-1:0] cur_addr;
  logic              wrap;
  logic              last_row;
  logic [COL_W-1:0]  adv_col;
  logic [ROW_W-1:0]  adv_row;

  assign cur_addr = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign wrap     = (col_r == COL_W'(COLUMNS - 1));
  assign last_row = (row_r == ROW_W'(TEXT_ROWS - 1));
  assign adv_col  = wrap ? '0 : col_r + COL_W'(1);
  assign adv_row  = wrap ? row_r + ROW_W'(1) : row_r;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cnt_nxt   = cnt_r;
    ch_nxt    = ch_r;
    fore_nxt  = fore_r;
    baddr_nxt = baddr_r;
    hit_nxt   = hit_r;
    rcell_nxt = rcell_r;
    mem_req   = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = (cnt_r < ADDR_W'(TEXT_CELLS)) ? BLANK_CELL : WHITE_CELL;
        cnt_nxt       = cnt_r + ADDR_W'(1);
        if (cnt_r == ADDR_W'(ALL_CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rcell_nxt = '0;
          fore_nxt  = in_color;
          ch_nxt    = in_char_code;
          state_nxt = ST_DONE;
          unique case (op_t'(in_operation))
            OP_PUT: begin
              unique case (in_char_code)
                CH_CR: begin
                  col_nxt = '0;
                end
                CH_LF: begin
                  col_nxt = '0;
                  if (last_row) begin
                    cnt_nxt   = '0;
                    state_nxt = ST_SCROLL;
                  end else begin
                    row_nxt = row_r + ROW_W'(1);
                  end
                end
                CH_BS: begin
                  // nothing to do at the origin
                  if (col_r != '0 || row_r != '0) begin
                    if (col_r == '0) begin
                      col_nxt = COL_W'(COLUMNS - 1);
                      row_nxt = row_r - ROW_W'(1);
                    end else begin
                      col_nxt = col_r - COL_W'(1);
                    end
                    mem_req.we    = 1'b1;
                    mem_req.waddr = cur_addr - ADDR_W'(1);
                    mem_req.wdata = {NIB_W'(0), in_color, CH_SPACE};
                  end
                end
                CH_TAB: begin
                  state_nxt = ST_TAB;
                end
                default: begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = cur_addr;
                  mem_req.wdata = {NIB_W'(0), in_color, in_char_code};
                  col_nxt       = adv_col;
                  row_nxt       = adv_row;
                  if (wrap && last_row) begin
                    row_nxt   = row_r;
                    cnt_nxt   = '0;
                    state_nxt = ST_SCROLL;
                  end
                end
              endcase
            end
            OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            OP_BAR: begin
              if (in_cell_index < IDX_W'(COLUMNS)) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ADDR_W'(TEXT_CELLS) + in_cell_index[ADDR_W-1:0];
                baddr_nxt     = ADDR_W'(TEXT_CELLS) + in_cell_index[ADDR_W-1:0];
                state_nxt     = ST_BAR;
              end
            end
            OP_READ: begin
              hit_nxt       = (in_cell_index < IDX_W'(ALL_CELLS));
              mem_req.re    = 1'b1;
              mem_req.raddr = in_cell_index[ADDR_W-1:0];
              state_nxt     = ST_READ;
            end
          endcase
        end
      end

      ST_TAB: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur_addr;
        mem_req.wdata = {NIB_W'(0), fore_r, CH_SPACE};
        col_nxt       = adv_col;
        row_nxt       = adv_row;
        if ((adv_col & TAB_MASK) == '0) begin
          if (wrap && last_row) begin
            row_nxt   = row_r;
            cnt_nxt   = '0;
            state_nxt = ST_SCROLL;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_BAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = baddr_r;
        mem_req.wdata = {mem_rdata[CELL_W-1:CHAR_W], ch_r};
        state_nxt     = ST_DONE;
      end

      ST_READ: begin
        rcell_nxt = hit_r ? mem_rdata : '0;
        state_nxt = ST_DONE;
      end

      ST_SCROLL: begin
        // read one row ahead, write the word read last cycle one row up
        if (cnt_r < ADDR_W'(MOVE_CELLS)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cnt_r + ADDR_W'(COLUMNS);
        end
        if (cnt_r != '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cnt_r - ADDR_W'(1);
          mem_req.wdata = mem_rdata;
        end
        if (cnt_r == ADDR_W'(MOVE_CELLS)) begin
          state_nxt = ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end

      ST_BLANK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = BLANK_CELL;
        cnt_nxt       = cnt_r + ADDR_W'(1);
        if (cnt_r == ADDR_W'(TEXT_CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_INIT;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    res.pos   = POS_W'(cur_addr);
    res.col   = col_r;
    res.row   = row_r;
    res.rchar = rcell_r[CHAR_W-1:0];
    res.rfore = rcell_r[CHAR_W+NIB_W-1:CHAR_W];
    res.rback = rcell_r[CELL_W-1:CHAR_W+NIB_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r    <= ch_nxt;
    fore_r  <= fore_nxt;
    baddr_r <= baddr_nxt;
    hit_r   <= hit_nxt;
    rcell_r <= rcell_nxt;
  end

endmodule

FILE: sv/text_console_writer.sv
// text console writer: character-cell screen with a cursor and a status bar row
//
// input channel (in_valid/in_ready): one word per operation - put character,
// clear screen, set status bar character, read cell.
// result channel (out_valid/out_ready): one word per operation with the cursor
// after it and, for reads, the cell contents.
// puts, cr, lf, bs and out-of-range bar writes are done at accept; bar writes and
// reads go through a memory read; tab writes blank cells one per cycle up to
// the next tab stop; a put that scrolls adds a read/write copy of the text rows
// one cell per cycle, then blanking the bottom row; clear walks all 2000 cells
// one per cycle. items are worked on one at a time over the single screen
// memory port pair, and the next word is taken once a result has moved into
// the output register.
// after reset every cell of the screen memory is swept, in_ready low.
// a result waiting on a stalled receiver sits in the output register; the next
// word is still accepted and worked, and its result waits until the register
// frees up.
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"

module text_console_writer
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [NIB_W-1:0]  in_color,
  input  logic [IDX_W-1:0]  in_cell_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  out_cursor_position,
  output logic [COL_W-1:0]  out_cursor_column,
  output logic [ROW_W-1:0]  out_cursor_line,
  output logic [CHAR_W-1:0] out_read_char,
  output logic [NIB_W-1:0]  out_read_fore,
  output logic [NIB_W-1:0]  out_read_back
);

  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_take;
  res_t              res;

  logic              out_valid_r, out_valid_nxt;
  res_t              out_r;

  logic              cursor_in_text;
  logic              cursor_pos_ok;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (ALL_CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  tcw_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_char_code  (in_char_code),
    .in_color      (in_color),
    .in_cell_index (in_cell_index),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  // output register frees when empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_r.pos;
  assign out_cursor_column   = out_r.col;
  assign out_cursor_line     = out_r.row;
  assign out_read_char       = out_r.rchar;
  assign out_read_fore       = out_r.rfore;
  assign out_read_back       = out_r.rback;

  assign cursor_in_text = (out_cursor_column < COL_W'(COLUMNS)) &&
                          (out_cursor_line < ROW_W'(TEXT_ROWS));
  assign cursor_pos_ok  = out_cursor_position ==
                          (POS_W'(out_cursor_line) * POS_W'(COLUMNS) +
                           POS_W'(out_cursor_column));

  `TCW_ASSERT_NOW(a_cursor_range, out_valid, cursor_in_text, "cursor out of the text area")
  `TCW_ASSERT_NOW(a_cursor_pos, out_valid, cursor_pos_ok, "cursor position off column/line")
  `TCW_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "word taken while busy")
  `TCW_ASSERT_NOW(a_no_result_idle, in_ready, !res_valid, "result pending while idle")

endmodule
